// ===== hw/rtl/spel_pkg.sv =====
// Shared types, constants and register codes of the encoder speed loop.
`default_nettype none

package spel_pkg;

    localparam int CntW   = 16;
    localparam int TgtW   = 12;
    localparam int GainW  = 12;
    localparam int MaxW   = 15;
    localparam int MinW   = 16;
    localparam int SumW   = 32;
    localparam int DrvW   = 16;
    localparam int WideW  = 34;
    localparam int IntW   = 29;
    localparam int TotW   = 37;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // Reciprocal of one thousand, exact for magnitudes below 2**MagW.
    localparam int MagW     = 25;
    localparam int MagicW   = 26;
    localparam int DivShift = 35;
    localparam logic [MagicW-1:0] DIV_MAGIC = 26'd34359739;

    localparam logic [GainW-1:0]       KP_RESET        = 12'd34;
    localparam logic [GainW-1:0]       KI_RESET        = 12'd41;
    localparam logic [GainW-1:0]       KD_RESET        = 12'd0;
    localparam logic [MaxW-1:0]        SPEED_MAX_RESET = 15'd9000;
    localparam logic signed [MinW-1:0] SPEED_MIN_RESET = -16'sd9000;

    localparam logic signed [IntW-1:0] TRIP_HIGH = 29'sd9000000;
    localparam logic signed [IntW-1:0] TRIP_LOW  = -29'sd9000000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_KP        = 3'd0,
        CFG_KI        = 3'd1,
        CFG_KD        = 3'd2,
        CFG_SPEED_MAX = 3'd3,
        CFG_SPEED_MIN = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [GainW-1:0]       kp;
        logic [GainW-1:0]       ki;
        logic [GainW-1:0]       kd;
        logic [MaxW-1:0]        speed_max;
        logic signed [MinW-1:0] speed_min;
    } cfg_t;

    typedef struct packed {
        logic                   kind;
        logic signed [CntW-1:0] left_count;
        logic signed [CntW-1:0] right_count;
        logic [TgtW-1:0]        target_speed;
    } item_t;

    typedef struct packed {
        logic signed [DrvW-1:0] err;
        logic signed [DrvW-1:0] dif;
    } err_beat_t;

    typedef struct packed {
        logic signed [IntW-1:0] p_raw;
        logic signed [IntW-1:0] i_inc;
        logic signed [IntW-1:0] d_raw;
    } terms_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spel_cfg_regs.sv =====
// Gain and limit registers with their write port.
`default_nettype none

module spel_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [spel_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [spel_pkg::CfgDatW-1:0]   cfg_data,
    output spel_pkg::cfg_t                      cfg
);
    import spel_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.ki        <= KI_RESET;
            cfg_reg.kd        <= KD_RESET;
            cfg_reg.speed_max <= SPEED_MAX_RESET;
            cfg_reg.speed_min <= SPEED_MIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_KP:        cfg_reg.kp        <= cfg_data[GainW-1:0];
                CFG_KI:        cfg_reg.ki        <= cfg_data[GainW-1:0];
                CFG_KD:        cfg_reg.kd        <= cfg_data[GainW-1:0];
                CFG_SPEED_MAX: cfg_reg.speed_max <= cfg_data[MaxW-1:0];
                CFG_SPEED_MIN: cfg_reg.speed_min <= $signed(cfg_data[MinW-1:0]);
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spel_err_stage.sv =====
// Input register, encoder sum, speed error and speed change stage.
`default_nettype none

module spel_err_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire spel_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output spel_pkg::err_beat_t  out_beat
);
    import spel_pkg::*;

    function automatic logic signed [WideW-1:0] half_trunc(input logic signed [WideW-1:0] x);
        logic signed [WideW-1:0] adj;
        adj = x + $signed({{(WideW-1){1'b0}}, x[WideW-1]});
        return adj >>> 1;
    endfunction

    function automatic logic signed [DrvW-1:0] sat16(input logic signed [WideW-1:0] x);
        logic signed [DrvW-1:0] r;
        if (x > 34'sd32767)
            r = 16'sh7FFF;
        else if (x < -34'sd32768)
            r = 16'sh8000;
        else
            r = x[DrvW-1:0];
        return r;
    endfunction

    logic                    a_valid_reg;
    item_t                   a_item_reg;
    logic                    b_valid_reg;
    err_beat_t               b_beat_reg;
    err_beat_t               b_beat_next;
    logic [SumW-1:0]         count_sum_reg;
    logic [SumW-1:0]         count_sum_next;
    logic signed [DrvW-1:0]  last_speed_reg;
    logic signed [DrvW-1:0]  last_speed_next;
    logic                    a_go;
    logic                    b_load;
    logic                    in_fire;
    logic signed [WideW-1:0] sum2_x;
    logic signed [WideW-1:0] err2;
    logic signed [WideW-1:0] dif2;

    assign b_load   = a_valid_reg && a_item_reg.kind && (!b_valid_reg || out_ready);
    assign a_go     = a_valid_reg && (!a_item_reg.kind || !b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_go;
    assign in_fire  = in_valid && in_ready;

    assign sum2_x = $signed({{(WideW-SumW){count_sum_reg[SumW-1]}}, count_sum_reg});
    assign err2   = $signed({{(WideW-TgtW-1){1'b0}}, a_item_reg.target_speed, 1'b0}) - sum2_x;
    assign dif2   = sum2_x
                  - $signed({{(WideW-DrvW-1){last_speed_reg[DrvW-1]}}, last_speed_reg, 1'b0});

    always_comb
    begin
        count_sum_next  = count_sum_reg;
        last_speed_next = last_speed_reg;
        if (a_go && !a_item_reg.kind)
        begin
            count_sum_next = count_sum_reg
                + {{(SumW-CntW){a_item_reg.left_count[CntW-1]}}, a_item_reg.left_count}
                + {{(SumW-CntW){a_item_reg.right_count[CntW-1]}}, a_item_reg.right_count};
        end
        else if (b_load)
        begin
            count_sum_next  = '0;
            last_speed_next = sat16(half_trunc(sum2_x));
        end
        b_beat_next.err = sat16(half_trunc(err2));
        b_beat_next.dif = sat16(half_trunc(dif2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            count_sum_reg  <= '0;
            last_speed_reg <= '0;
        end
        else
        begin
            if (in_fire)
                a_valid_reg <= 1'b1;
            else if (a_go)
                a_valid_reg <= 1'b0;
            if (b_load)
                b_valid_reg <= 1'b1;
            else if (out_ready)
                b_valid_reg <= 1'b0;
            count_sum_reg  <= count_sum_next;
            last_speed_reg <= last_speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            a_item_reg <= in_item;
        if (b_load)
            b_beat_reg <= b_beat_next;
    end

    assign out_valid = b_valid_reg;
    assign out_beat  = b_beat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spel_pid_terms.sv =====
// Gain products, integral update with trip, and total in thousandths.
`default_nettype none

module spel_pid_terms (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spel_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire spel_pkg::err_beat_t           in_beat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [spel_pkg::TotW-1:0]   out_total
);
    import spel_pkg::*;

    logic                   c_valid_reg;
    terms_t                 c_terms_reg;
    terms_t                 c_terms_next;
    logic                   d_valid_reg;
    logic signed [TotW-1:0] d_total_reg;
    logic signed [TotW-1:0] d_total_next;
    logic signed [IntW-1:0] integral_reg;
    logic signed [IntW-1:0] integral_next;
    logic signed [IntW-1:0] integral_sum;
    logic signed [IntW-1:0] hi_th;
    logic signed [IntW-1:0] lo_th;
    logic signed [IntW-1:0] err_x;
    logic signed [IntW-1:0] dif_x;
    logic                   c_load;
    logic                   d_load;

    assign d_load   = c_valid_reg && (!d_valid_reg || out_ready);
    assign in_ready = !c_valid_reg || d_load;
    assign c_load   = in_valid && in_ready;

    assign err_x = $signed({{(IntW-DrvW){in_beat.err[DrvW-1]}}, in_beat.err});
    assign dif_x = $signed({{(IntW-DrvW){in_beat.dif[DrvW-1]}}, in_beat.dif});

    assign c_terms_next.p_raw = err_x * $signed({{(IntW-GainW){1'b0}}, cfg.kp});
    assign c_terms_next.i_inc = err_x * $signed({{(IntW-GainW){1'b0}}, cfg.ki});
    assign c_terms_next.d_raw = dif_x * $signed({{(IntW-GainW){1'b0}}, cfg.kd});

    assign hi_th = $signed({{(IntW-MaxW){1'b0}}, cfg.speed_max}) * 29'sd1000;
    assign lo_th = $signed({{(IntW-MinW){cfg.speed_min[MinW-1]}}, cfg.speed_min}) * 29'sd1000;
    assign integral_sum = integral_reg + c_terms_reg.i_inc;

    always_comb
    begin
        if (integral_sum > hi_th)
            integral_next = TRIP_HIGH;
        else if (integral_sum < lo_th)
            integral_next = TRIP_LOW;
        else
            integral_next = integral_sum;
        d_total_next =
              $signed({{(TotW-IntW){c_terms_reg.p_raw[IntW-1]}}, c_terms_reg.p_raw}) * 37'sd100
            + $signed({{(TotW-IntW){integral_next[IntW-1]}}, integral_next})
            + $signed({{(TotW-IntW){c_terms_reg.d_raw[IntW-1]}}, c_terms_reg.d_raw}) * 37'sd10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            integral_reg <= '0;
        end
        else
        begin
            if (c_load)
                c_valid_reg <= 1'b1;
            else if (d_load)
                c_valid_reg <= 1'b0;
            if (d_load)
            begin
                d_valid_reg  <= 1'b1;
                integral_reg <= integral_next;
            end
            else if (out_ready)
            begin
                d_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
            c_terms_reg <= c_terms_next;
        if (d_load)
            d_total_reg <= d_total_next;
    end

    assign out_valid = d_valid_reg;
    assign out_total = d_total_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spel_out_scale.sv =====
// Division of the total by one thousand, limit clamp and output register.
`default_nettype none

module spel_out_scale (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire spel_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [spel_pkg::TotW-1:0] in_total,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [spel_pkg::DrvW-1:0]   out_drive
);
    import spel_pkg::*;

    localparam int ProdW = MagW + MagicW;
    localparam int QW    = DrvW + 1;

    logic                   e_valid_reg;
    logic [DrvW-1:0]        e_quot_reg;
    logic                   e_neg_reg;
    logic                   f_valid_reg;
    logic signed [DrvW-1:0] f_drive_reg;
    logic signed [DrvW-1:0] f_drive_next;
    logic [TotW-1:0]        mag;
    logic [MagW-1:0]        mag_clip;
    logic [ProdW-1:0]       prod;
    logic signed [QW-1:0]   quot;
    logic signed [QW-1:0]   hi_q;
    logic signed [QW-1:0]   lo_q;
    logic                   e_load;
    logic                   f_load;

    assign f_load   = e_valid_reg && (!f_valid_reg || out_ready);
    assign in_ready = !e_valid_reg || f_load;
    assign e_load   = in_valid && in_ready;

    // Magnitudes past the reach of any limit are clipped; the clamp still sees them as beyond.
    assign mag      = in_total[TotW-1] ? $unsigned(-in_total) : $unsigned(in_total);
    assign mag_clip = (|mag[TotW-1:MagW]) ? {MagW{1'b1}} : mag[MagW-1:0];
    assign prod     = {{MagicW{1'b0}}, mag_clip} * {{MagW{1'b0}}, DIV_MAGIC};

    assign quot = e_neg_reg ? -$signed({1'b0, e_quot_reg}) : $signed({1'b0, e_quot_reg});
    assign hi_q = $signed({{(QW-MaxW){1'b0}}, cfg.speed_max});
    assign lo_q = $signed({cfg.speed_min[MinW-1], cfg.speed_min});

    always_comb
    begin
        if (quot > hi_q)
            f_drive_next = hi_q[DrvW-1:0];
        else if (quot < lo_q)
            f_drive_next = lo_q[DrvW-1:0];
        else
            f_drive_next = quot[DrvW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_load)
                e_valid_reg <= 1'b1;
            else if (f_load)
                e_valid_reg <= 1'b0;
            if (f_load)
                f_valid_reg <= 1'b1;
            else if (out_ready)
                f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_load)
        begin
            e_quot_reg <= prod[DivShift +: DrvW];
            e_neg_reg  <= in_total[TotW-1];
        end
        if (f_load)
            f_drive_reg <= f_drive_next;
    end

    assign out_valid = f_valid_reg;
    assign out_drive = f_drive_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/speed_pid_encoder_loop_core.sv =====
// Top level of the encoder speed loop: PID controller with integral trip.
//
//   Channel   Side    Beat contents
//   s_axis    in      tuser: kind; tdata: left_count, right_count, target_speed
//   m_axis    out     tdata: drive
//   cfg       in      cfg_index selects kp, ki, kd, speed_max, speed_min
//
// One beat is taken every cycle unless all stages are full. A tick beat gives its
// drive after the input register, error stage, gain products, integral and total,
// reciprocal multiply by one thousandth, clamp and output register. A sample beat
// is absorbed in the error stage and gives no result. Reset clears all valid
// flags, the running sum, the last speed and the integral, and loads the default
// gains and limits. Each stage holds its beat while the next is full, so bubbles
// close up and a stall at the output reaches the input only when all stages fill.
`default_nettype none

module speed_pid_encoder_loop_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [47:0]                     s_tdata,  // left_count, right_count, target_speed, zeros
    input  wire logic [0:0]                      s_tuser,  // kind
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,  // drive
    input  wire logic                            cfg_wr_en,
    input  wire logic [spel_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [spel_pkg::CfgDatW-1:0]    cfg_data
);
    import spel_pkg::*;

    cfg_t                   cfg;
    item_t                  in_item;
    logic                   err_valid;
    logic                   err_ready;
    err_beat_t              err_beat;
    logic                   tot_valid;
    logic                   tot_ready;
    logic signed [TotW-1:0] tot_value;
    logic signed [DrvW-1:0] drive;

    assign in_item.kind         = s_tuser[0];
    assign in_item.left_count   = $signed(s_tdata[CntW-1:0]);
    assign in_item.right_count  = $signed(s_tdata[2*CntW-1:CntW]);
    assign in_item.target_speed = s_tdata[2*CntW +: TgtW];

    spel_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spel_err_stage u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_beat  (err_beat)
    );

    spel_pid_terms u_pid (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_beat   (err_beat),
        .out_valid (tot_valid),
        .out_ready (tot_ready),
        .out_total (tot_value)
    );

    spel_out_scale u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (tot_valid),
        .in_ready  (tot_ready),
        .in_total  (tot_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_drive (drive)
    );

    assign m_tdata = drive;

endmodule

`default_nettype wire
